// ===== src/exifo_pkg.sv =====
// ----------------------------------------------------------------------------
// EXIF orientation extractor package
// Shared types and constants for the TIFF header and first IFD parser.
// ----------------------------------------------------------------------------
package exifo_pkg;

   localparam int MAX_BLOB_BYTES_DEFAULT = 65536;

   localparam logic [7:0]  MARK_LITTLE    = 8'h49;
   localparam logic [7:0]  MARK_BIG       = 8'h4D;
   localparam logic [15:0] ORIENT_TAG     = 16'h0112;
   localparam logic [15:0] TYPE_SHORT     = 16'd3;
   localparam logic [31:0] COUNT_ONE      = 32'd1;
   localparam logic [31:0] MIN_IFD_OFFSET = 32'd8;
   localparam logic [15:0] ORIENT_NONE    = 16'd1;
   localparam logic [15:0] ORIENT_SWAP_LO = 16'd5;
   localparam logic [15:0] ORIENT_SWAP_HI = 16'd8;

   localparam int ENTRY_BYTES = 12;
   localparam int OFF_W       = $clog2(ENTRY_BYTES);
   localparam int NEED_W      = 34;

   localparam logic [OFF_W-1:0] OFF_TAG   = OFF_W'(1);
   localparam logic [OFF_W-1:0] OFF_TYPE  = OFF_W'(3);
   localparam logic [OFF_W-1:0] OFF_COUNT = OFF_W'(7);
   localparam logic [OFF_W-1:0] OFF_VALUE = OFF_W'(9);
   localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(ENTRY_BYTES - 1);

   typedef enum logic [1:0] {
      ORDER_UNKNOWN = 2'd0,
      ORDER_LITTLE  = 2'd1,
      ORDER_BIG     = 2'd2
   } order_type;

   typedef enum logic [1:0] {
      ST_SEARCH   = 2'd0,
      ST_IN_ENTRY = 2'd1,
      ST_FOUND    = 2'd2,
      ST_FAILED   = 2'd3
   } status_type;

endpackage

// ===== src/exif_orientation_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// EXIF orientation extractor
// Result: registered; it appears in the cycle after the transaction of the final byte.
// Throughput: one byte per cycle while the result register is free or drains in
// the same cycle; a result that waits for the receiver holds off every byte.
// Reset: synchronous; parser state returns to its start and after each final
// byte the parser restarts for the next blob.
// ----------------------------------------------------------------------------
module exif_orientation_extractor_unit #(
   parameter int MAX_BLOB_BYTES = exifo_pkg::MAX_BLOB_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_orientation,
   output logic        rsp_tag_found,
   output logic [1:0]  rsp_order_code,
   output logic        rsp_swaps_axes
);

   localparam int PW = $clog2(MAX_BLOB_BYTES + 1);
   localparam int OW = exifo_pkg::OFF_W;
   localparam int NW = exifo_pkg::NEED_W;

   logic [PW-1:0]         pos_ff, pos_in;
   logic [7:0]            first_byte_ff, first_byte_in;
   exifo_pkg::order_type  order_ff, order_in;
   logic [31:0]           ifd_ff, ifd_in;
   logic [15:0]           total_ff, total_in;
   logic [23:0]           shift_ff, shift_in;
   exifo_pkg::status_type status_ff, status_in;
   logic [15:0]           captured_ff, captured_in;
   logic                  table_ff, table_in;
   logic [OW-1:0]         off_ff, off_in;
   logic [15:0]           idx_ff, idx_in;
   logic [NW-1:0]         need_ff, need_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           orient_ff, orient_in;
   logic                  found_ff, found_in;
   logic [1:0]            code_ff, code_in;
   logic                  swap_ff, swap_in;

   logic                  accept;
   logic [31:0]           window;
   logic [15:0]           val2;
   logic [31:0]           val4;
   exifo_pkg::order_type  code_sel;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign window    = {shift_ff, req_data_byte};

   always_comb begin
      if (order_ff == exifo_pkg::ORDER_LITTLE) begin
         val2 = {window[7:0], window[15:8]};
         val4 = {window[7:0], window[15:8], window[23:16], window[31:24]};
      end else begin
         val2 = window[15:0];
         val4 = window;
      end
   end

   assign need_in = {2'b00, ifd_ff} + NW'(2)
                  + {{(NW-19){1'b0}}, total_ff, 3'b000}
                  + {{(NW-18){1'b0}}, total_ff, 2'b00};

   always_comb begin
      pos_in        = pos_ff;
      first_byte_in = first_byte_ff;
      order_in      = order_ff;
      ifd_in        = ifd_ff;
      total_in      = total_ff;
      shift_in      = shift_ff;
      status_in     = status_ff;
      captured_in   = captured_ff;
      table_in      = table_ff;
      off_in        = off_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      orient_in     = orient_ff;
      found_in      = found_ff;
      code_in       = code_ff;
      swap_in       = swap_ff;
      code_sel      = exifo_pkg::ORDER_UNKNOWN;

      if (accept) begin
         if (pos_ff < PW'(MAX_BLOB_BYTES)) begin
            shift_in = window[23:0];
            pos_in   = pos_ff + PW'(1);
            priority if (pos_ff == PW'(0)) begin
               first_byte_in = req_data_byte;
            end else if (pos_ff == PW'(1)) begin
               if (first_byte_ff == req_data_byte &&
                   req_data_byte == exifo_pkg::MARK_LITTLE) begin
                  order_in = exifo_pkg::ORDER_LITTLE;
               end else if (first_byte_ff == req_data_byte &&
                            req_data_byte == exifo_pkg::MARK_BIG) begin
                  order_in = exifo_pkg::ORDER_BIG;
               end else begin
                  order_in  = exifo_pkg::ORDER_UNKNOWN;
                  status_in = exifo_pkg::ST_FAILED;
               end
            end else if (pos_ff == PW'(7)) begin
               ifd_in = val4;
               if (val4 < exifo_pkg::MIN_IFD_OFFSET) begin
                  status_in = exifo_pkg::ST_FAILED;
               end
            end else if (pos_ff > PW'(7) && status_ff != exifo_pkg::ST_FOUND &&
                         status_ff != exifo_pkg::ST_FAILED) begin
               if (!table_ff) begin
                  if ({{(33-PW){1'b0}}, pos_ff} == {1'b0, ifd_ff} + 33'd1) begin
                     total_in = val2;
                     table_in = 1'b1;
                     off_in   = '0;
                     idx_in   = '0;
                  end
               end else if (idx_ff < total_ff) begin
                  if (off_ff == exifo_pkg::OFF_LAST) begin
                     off_in = '0;
                     idx_in = idx_ff + 16'd1;
                  end else begin
                     off_in = off_ff + OW'(1);
                  end
                  priority if (off_ff == exifo_pkg::OFF_TAG) begin
                     if (val2 == exifo_pkg::ORIENT_TAG) begin
                        status_in = exifo_pkg::ST_IN_ENTRY;
                     end
                  end else if (status_ff == exifo_pkg::ST_IN_ENTRY) begin
                     priority if (off_ff == exifo_pkg::OFF_TYPE) begin
                        if (val2 != exifo_pkg::TYPE_SHORT) begin
                           status_in = exifo_pkg::ST_FAILED;
                        end
                     end else if (off_ff == exifo_pkg::OFF_COUNT) begin
                        if (val4 != exifo_pkg::COUNT_ONE) begin
                           status_in = exifo_pkg::ST_FAILED;
                        end
                     end else if (off_ff == exifo_pkg::OFF_VALUE) begin
                        captured_in = val2;
                        status_in   = exifo_pkg::ST_FOUND;
                     end else begin
                        status_in = status_ff;
                     end
                  end else begin
                     status_in = status_ff;
                  end
               end
            end else begin
               status_in = status_ff;
            end
         end

         if (req_is_final) begin
            code_sel = (pos_in >= PW'(8)) ? order_in : exifo_pkg::ORDER_UNKNOWN;
            found_in = code_sel != exifo_pkg::ORDER_UNKNOWN &&
                       status_in == exifo_pkg::ST_FOUND &&
                       {{(NW-PW){1'b0}}, pos_in} >= need_ff;
            orient_in    = found_in ? captured_in : exifo_pkg::ORIENT_NONE;
            code_in      = code_sel;
            swap_in      = orient_in >= exifo_pkg::ORIENT_SWAP_LO &&
                           orient_in <= exifo_pkg::ORIENT_SWAP_HI;
            rsp_valid_in = 1'b1;

            pos_in        = '0;
            first_byte_in = '0;
            order_in      = exifo_pkg::ORDER_UNKNOWN;
            ifd_in        = '0;
            total_in      = '0;
            shift_in      = '0;
            status_in     = exifo_pkg::ST_SEARCH;
            captured_in   = exifo_pkg::ORIENT_NONE;
            table_in      = 1'b0;
            off_in        = '0;
            idx_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         first_byte_ff <= '0;
         order_ff      <= exifo_pkg::ORDER_UNKNOWN;
         ifd_ff        <= '0;
         total_ff      <= '0;
         shift_ff      <= '0;
         status_ff     <= exifo_pkg::ST_SEARCH;
         captured_ff   <= exifo_pkg::ORIENT_NONE;
         table_ff      <= 1'b0;
         off_ff        <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         first_byte_ff <= first_byte_in;
         order_ff      <= order_in;
         ifd_ff        <= ifd_in;
         total_ff      <= total_in;
         shift_ff      <= shift_in;
         status_ff     <= status_in;
         captured_ff   <= captured_in;
         table_ff      <= table_in;
         off_ff        <= off_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff   <= need_in;
      orient_ff <= orient_in;
      found_ff  <= found_in;
      code_ff   <= code_in;
      swap_ff   <= swap_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_orientation = orient_ff;
   assign rsp_tag_found   = found_ff;
   assign rsp_order_code  = code_ff;
   assign rsp_swaps_axes  = swap_ff;

endmodule

// ===== src/exifo_port_checker.sv =====
// ----------------------------------------------------------------------------
// EXIF orientation extractor port checker
// Checks result consistency and handshake behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module exifo_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_is_final,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_orientation,
   input logic        rsp_tag_found,
   input logic [1:0]  rsp_order_code,
   input logic        rsp_swaps_axes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_orientation) &&
                                  $stable(rsp_tag_found) && $stable(rsp_order_code))
      else $error("A stalled result transaction changed.");

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_final |=> rsp_valid)
      else $error("A final byte transaction produced no result.");

   a_not_found_default: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tag_found |-> rsp_orientation == exifo_pkg::ORIENT_NONE)
      else $error("A result without a find carries a non-default orientation.");

   a_found_has_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_order_code == exifo_pkg::ORDER_UNKNOWN && !rsp_tag_found) ||
                    rsp_order_code == exifo_pkg::ORDER_LITTLE ||
                    rsp_order_code == exifo_pkg::ORDER_BIG)
      else $error("The byte order code does not match the find.");

   a_swap_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_swaps_axes == (rsp_orientation >= exifo_pkg::ORIENT_SWAP_LO &&
                                       rsp_orientation <= exifo_pkg::ORIENT_SWAP_HI))
      else $error("The axis swap flag does not match the orientation.");

endmodule

bind exif_orientation_extractor_unit exifo_port_checker u_exifo_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_is_final    (req_is_final),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_orientation (rsp_orientation),
   .rsp_tag_found   (rsp_tag_found),
   .rsp_order_code  (rsp_order_code),
   .rsp_swaps_axes  (rsp_swaps_axes)
);
